FILE: design/rdsb_pkg.sv
// rdsb_pkg: shared types and constants for the row downsampling boxcar block.
// No dependencies; imported by every module of the block.
package rdsb_pkg;

  localparam int SUM_W      = 36;  // up to sixteen signed 32-bit terms
  localparam int IDX_W      = 8;   // column and window slot fields of a job
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_EXTRA = 2'd3;

  typedef struct packed {
    logic [4:0]  column_count;
    logic [15:0] total_rows;
    logic [15:0] target_rows;
    logic [3:0]  window_extra;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               table_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic [3:0]         out_column;
    logic signed [31:0] average;
    logic               beyond_table;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               beyond;
    logic [IDX_W-1:0]   col;
    logic [15:0]        row;
    logic [IDX_W-1:0]   phase;
    logic [3:0]         extra;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_AVG,
    BK_ROW,
    BK_DONE
  } bk_state_t;

endpackage

FILE: design/row_downsample_boxcar.sv
// row_downsample_boxcar: top level; configuration registers, front end, job
// queue, back end and shared divider. Depends on rdsb_pkg and the rdsb_* modules.
//
// Samples arrive row-major, one per item, and each gives one result: the
// trailing boxcar average of its column over the current row and up to
// window_extra earlier rows (fewer near the top of the table), truncated
// toward zero, tagged with row floor(row*target_rows/total_rows) and its
// column. Samples past total_rows, or any sample while target_rows is zero,
// come back flagged with zero row and average.
// An in-table item holds the back end through the pop, one history read per
// earlier row averaged (up to 15 of them) and the addition of the last of them,
// the start of the divider, two passes of the shared bit-serial divider (36
// steps and a done strobe each), first for the average and then for the output
// row, and the load of the output register. A flagged item goes from the pop
// straight to the output register. The job queue holds up to two further
// items, and a finished result waits in the output register while the next
// item is worked on.
module row_downsample_boxcar #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rdsb_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rdsb_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [rdsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rdsb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rdsb_pkg::*;

  cfg_t     cfg_r;
  job_t     push_job, head;
  logic     job_push, job_full, job_pop, job_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_count <= 5'd1;
      cfg_r.total_rows   <= 16'd1;
      cfg_r.target_rows  <= 16'd1;
      cfg_r.window_extra <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: cfg_r.column_count <= cfg_data[4:0];
        REG_TOTAL_ROWS:   cfg_r.total_rows   <= cfg_data[15:0];
        REG_TARGET_ROWS:  cfg_r.target_rows  <= cfg_data[15:0];
        REG_WINDOW_EXTRA: cfg_r.window_extra <= cfg_data[3:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  rdsb_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .job_push (job_push),
    .job      (push_job),
    .job_full (job_full)
  );

  rdsb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .head     (head),
    .empty    (job_empty)
  );

  rdsb_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .empty     (job_empty),
    .pop       (job_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  rdsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

FILE: design/rdsb_front.sv
// rdsb_front: accepts items, tracks column, row and window slot, and classifies
// each item into a job for the back end. Depends on rdsb_pkg.
module rdsb_front #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_WINDOW  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdsb_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  rdsb_pkg::in_item_t in_item,
  output logic               job_push,
  output rdsb_pkg::job_t     job,
  input  logic               job_full
);
  import rdsb_pkg::*;

  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WIW = $clog2(MAX_WINDOW);

  logic [CIW-1:0] col_r, col_nxt, col_cur;
  logic [15:0]    row_r, row_nxt, row_cur;
  logic [WIW-1:0] phase_r, phase_nxt, phase_cur;
  logic [CIW:0]   cols_eff, col_inc;
  logic [3:0]     extra;
  logic           accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && !job_full;
  assign job_push = accept;

  always_comb begin
    col_cur   = in_item.table_start ? '0 : col_r;
    row_cur   = in_item.table_start ? '0 : row_r;
    phase_cur = in_item.table_start ? '0 : phase_r;

    if (cfg.column_count == '0) begin
      cols_eff = (CIW+1)'(1);
    end else if (32'(cfg.column_count) > MAX_COLUMNS) begin
      cols_eff = (CIW+1)'(MAX_COLUMNS);
    end else begin
      cols_eff = (CIW+1)'(cfg.column_count);
    end

    extra = cfg.window_extra;
    if (32'(extra) > MAX_WINDOW - 1) begin
      extra = 4'(MAX_WINDOW - 1);
    end
    if (row_cur < 16'(extra)) begin
      extra = row_cur[3:0];
    end

    col_inc   = (CIW+1)'(col_cur) + 1'b1;
    col_nxt   = col_inc[CIW-1:0];
    row_nxt   = row_cur;
    phase_nxt = phase_cur;
    if (col_inc >= cols_eff) begin
      col_nxt = '0;
      if (row_cur != 16'hFFFF) begin
        row_nxt   = row_cur + 16'd1;
        phase_nxt = (phase_cur == WIW'(MAX_WINDOW - 1)) ? '0 : phase_cur + 1'b1;
      end
    end

    job.sample = in_item.sample;
    job.beyond = (row_cur >= cfg.total_rows) || (cfg.target_rows == '0);
    job.col    = IDX_W'(col_cur);
    job.row    = row_cur;
    job.phase  = IDX_W'(phase_cur);
    job.extra  = extra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: design/rdsb_queue.sv
// rdsb_queue: two-entry job queue between the front and back ends.
// Depends on rdsb_pkg for the job type.
module rdsb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rdsb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rdsb_pkg::job_t head,
  output logic           empty
);
  import rdsb_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> !push)
    else $error("queue pushed while full");

endmodule

FILE: design/rdsb_div.sv
// rdsb_div: shared restoring divider, one quotient bit per cycle.
// Unsigned SUM_W-bit dividend by 16-bit divisor. Depends on rdsb_pkg.
module rdsb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rdsb_pkg::div_req_t req,
  output rdsb_pkg::div_rsp_t rsp
);
  import rdsb_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] quo_r;
  logic [15:0]      rem_r, dvs_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [16:0]      trial;
  logic             q_bit;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]} - {1'b0, dvs_r};
    if (!trial[16]) begin
      rem_nxt = trial[15:0];
      q_bit   = 1'b1;
    end else begin
      rem_nxt = {rem_r[14:0], quo_r[SUM_W-1]};
      q_bit   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !req.start) |=> (done_r && !busy_r))
    else $error("divider did not finish after last step");

endmodule

FILE: design/rdsb_back.sv
// rdsb_back: runs one job at a time: history write, window sum over the
// history memory, average and row division, output register. Depends on rdsb_pkg.
module rdsb_back #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rdsb_pkg::cfg_t      cfg,
  input  rdsb_pkg::job_t      head,
  input  logic                empty,
  output logic                pop,
  output rdsb_pkg::div_req_t  div_req,
  input  rdsb_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output rdsb_pkg::out_item_t out_item
);
  import rdsb_pkg::*;

  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WIW = $clog2(MAX_WINDOW);

  bk_state_t state_r, state_nxt;

  job_t                    job_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]        sum_mag;
  logic [3:0]              left_r;
  logic                    rd_pend_r;
  logic [WIW-1:0]          rd_ptr_r, head_prev;
  logic [31:0]             prod_r;
  logic [31:0]             rdata_r;
  logic [31:0]             hist_mem [MAX_COLUMNS][MAX_WINDOW];
  logic [31:0]             quo_lo;
  out_item_t               res_r, out_item_r;
  logic                    out_valid_r;
  logic                    mem_we, mem_re, sum_last, load_out;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          state_nxt = head.beyond ? BK_DONE : BK_SUM;
        end
      end
      BK_SUM: begin
        if (left_r == '0 && !rd_pend_r) begin
          state_nxt = BK_AVG;
        end
      end
      BK_AVG: begin
        if (div_rsp.done) begin
          state_nxt = BK_ROW;
        end
      end
      BK_ROW: begin
        if (div_rsp.done) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop      = (state_r == BK_IDLE) && !empty;
    mem_we   = pop && !head.beyond;
    mem_re   = (state_r == BK_SUM) && (left_r != '0);
    sum_last = (state_r == BK_SUM) && (left_r == '0) && !rd_pend_r;
    load_out = (state_r == BK_DONE) && (!out_valid_r || out_ready);
    sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

    div_req.start = sum_last || ((state_r == BK_AVG) && div_rsp.done);
    if (state_r == BK_SUM) begin
      div_req.dividend = sum_mag;
      div_req.divisor  = 16'(job_r.extra) + 16'd1;
    end else begin
      div_req.dividend = SUM_W'(prod_r);
      div_req.divisor  = cfg.total_rows;
    end
  end

  assign head_prev = (head.phase[WIW-1:0] == '0) ? WIW'(MAX_WINDOW - 1)
                                                 : head.phase[WIW-1:0] - 1'b1;
  assign quo_lo    = div_rsp.quotient[31:0];

  // history memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[head.col[CIW-1:0]][head.phase[WIW-1:0]] <= head.sample;
    end
    if (mem_re) begin
      rdata_r <= hist_mem[job_r.col[CIW-1:0]][rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r                <= head;
      sum_r                <= {{(SUM_W-32){head.sample[31]}}, head.sample};
      left_r               <= head.extra;
      rd_ptr_r             <= head_prev;
      prod_r               <= 32'(head.row) * 32'(cfg.target_rows);
      res_r.out_row        <= '0;
      res_r.out_column     <= head.col[3:0];
      res_r.average        <= '0;
      res_r.beyond_table   <= head.beyond;
    end else begin
      if (mem_re) begin
        left_r   <= left_r - 4'd1;
        rd_ptr_r <= (rd_ptr_r == '0) ? WIW'(MAX_WINDOW - 1) : rd_ptr_r - 1'b1;
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + {{(SUM_W-32){rdata_r[31]}}, rdata_r};
      end
      if (state_r == BK_AVG && div_rsp.done) begin
        res_r.average <= sum_r[SUM_W-1] ? -quo_lo : quo_lo;
      end
      if (state_r == BK_ROW && div_rsp.done) begin
        res_r.out_row <= div_rsp.quotient[15:0];
      end
    end
    if (load_out) begin
      out_item_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= mem_re;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_read_only_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == BK_SUM))
    else $error("history read pending outside summing");

  a_job_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.beyond) |=> (state_r == BK_SUM && !rd_pend_r))
    else $error("in-table job did not enter summing");

endmodule
